// File: hdl/uapq_pkg.sv
package uapq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRI_W  = 16;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;
    localparam int STEP_W = 4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [PRI_W-1:0]  pri;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_INSERT,
        OP_DEL_INIT,
        OP_SCAN,
        OP_CMP_LAST,
        OP_SHIFT_PREP,
        OP_SHIFT,
        OP_SHIFT_LAST,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_IS_INSERT,
        C_EMPTY,
        C_MORE,
        C_BEST_LAST,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam logic [STEP_W-1:0] S_IDLE       = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH   = 4'd1;
    localparam logic [STEP_W-1:0] S_DEL_INIT   = 4'd2;
    localparam logic [STEP_W-1:0] S_SCAN       = 4'd3;
    localparam logic [STEP_W-1:0] S_SCAN_LAST  = 4'd4;
    localparam logic [STEP_W-1:0] S_SHIFT_PREP = 4'd5;
    localparam logic [STEP_W-1:0] S_SHIFT      = 4'd6;
    localparam logic [STEP_W-1:0] S_SHIFT_LAST = 4'd7;
    localparam logic [STEP_W-1:0] S_INSERT     = 4'd8;
    localparam logic [STEP_W-1:0] S_FIN        = 4'd9;
    localparam logic [STEP_W-1:0] S_FIN_WAIT   = 4'd10;

    // Microprogram: jump to target when the condition holds, else fall through.
    function automatic t_uword uapq_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            S_IDLE:       w = '{OP_LATCH,      C_NO_ACCEPT, S_IDLE};
            S_DISPATCH:   w = '{OP_NONE,       C_IS_INSERT, S_INSERT};
            S_DEL_INIT:   w = '{OP_DEL_INIT,   C_EMPTY,     S_FIN};
            S_SCAN:       w = '{OP_SCAN,       C_MORE,      S_SCAN};
            S_SCAN_LAST:  w = '{OP_CMP_LAST,   C_NEXT,      S_IDLE};
            S_SHIFT_PREP: w = '{OP_SHIFT_PREP, C_BEST_LAST, S_SHIFT_LAST};
            S_SHIFT:      w = '{OP_SHIFT,      C_MORE,      S_SHIFT};
            S_SHIFT_LAST: w = '{OP_SHIFT_LAST, C_ALWAYS,    S_FIN};
            S_INSERT:     w = '{OP_INSERT,     C_NEXT,      S_IDLE};
            S_FIN:        w = '{OP_FINISH,     C_OUT_FREE,  S_IDLE};
            S_FIN_WAIT:   w = '{OP_NONE,       C_ALWAYS,    S_FIN};
            default:      w = '{OP_NONE,       C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/unsorted_array_priority_queue_unit.sv
// Priority queue of up to 16 entries (32-bit signed data, 16-bit priority,
// lower number served first) kept unsorted in a single-port-write RAM. Every
// input item yields exactly one result item. A delete scans the held entries
// for the minimum with one RAM read per cycle, then closes the gap with one
// read and one write per cycle; a delete on an empty queue does neither. A new
// item is taken while the previous result still waits in the output register.
module unsorted_array_priority_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // item_data[31:0], item_priority[47:32]
    input  logic        s_axis_tuser,  // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // out_data[31:0], out_priority[47:32],
                                       // occupancy[52:48], zero[55:53]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int IDX_W  = uapq_pkg::IDX_W;
    localparam int CNT_W  = uapq_pkg::CNT_W;
    localparam int PRI_W  = uapq_pkg::PRI_W;
    localparam int DATA_W = uapq_pkg::DATA_W;
    localparam int STEP_W = uapq_pkg::STEP_W;

    // sequencer
    logic [STEP_W-1:0] r_step, n_step;
    uapq_pkg::t_uword  uw;
    logic              cond_hit;

    // datapath
    logic                      r_act;
    uapq_pkg::t_entry          r_in;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_rd_vld;
    logic [IDX_W-1:0]          r_rd_idx;
    logic [PRI_W:0]            r_best_pri;   // extra bit holds the start sentinel
    logic [IDX_W-1:0]          r_best_idx;
    logic [DATA_W-1:0]         r_best_data;
    logic [DATA_W-1:0]         r_res_data;
    logic [PRI_W-1:0]          r_res_pri;
    logic [uapq_pkg::STAT_W-1:0] r_status;

    // output register
    logic                      r_out_valid;
    logic [55:0]               r_m_tdata;
    logic [1:0]                r_m_tuser;

    logic                      accept;
    logic                      out_free;
    logic                      better;
    logic                      we;
    logic [IDX_W-1:0]          wr_addr;
    uapq_pkg::t_entry          wr_data;
    uapq_pkg::t_entry          rd_data;

    assign uw       = uapq_pkg::uapq_rom(r_step);
    assign s_axis_tready = (uw.op == uapq_pkg::OP_LATCH);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign better   = r_rd_vld && ({1'b0, rd_data.pri} < r_best_pri);

    always_comb begin
        case (uw.cond)
            uapq_pkg::C_NEXT:      cond_hit = 1'b0;
            uapq_pkg::C_ALWAYS:    cond_hit = 1'b1;
            uapq_pkg::C_NO_ACCEPT: cond_hit = !accept;
            uapq_pkg::C_IS_INSERT: cond_hit = (r_act == uapq_pkg::ACT_INSERT);
            uapq_pkg::C_EMPTY:     cond_hit = (r_count == '0);
            uapq_pkg::C_MORE:      cond_hit = ((r_idx + 1'b1) < r_count);
            uapq_pkg::C_BEST_LAST: cond_hit = ((CNT_W'(r_best_idx) + 1'b1) == r_count);
            uapq_pkg::C_OUT_FREE:  cond_hit = out_free;
            default:               cond_hit = 1'b1;
        endcase
        n_step = cond_hit ? uw.target : r_step + 1'b1;
    end

    // single write port: appends on insert, closes the gap on delete
    always_comb begin
        we      = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = r_in;
        case (uw.op)
            uapq_pkg::OP_INSERT: begin
                we = (r_count != CNT_W'(uapq_pkg::DEPTH));
            end
            uapq_pkg::OP_SHIFT, uapq_pkg::OP_SHIFT_LAST: begin
                we      = r_rd_vld;
                wr_addr = r_rd_idx - 1'b1;
                wr_data = rd_data;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    uapq_store u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= uapq_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_rd_vld <= (uw.op == uapq_pkg::OP_SCAN) || (uw.op == uapq_pkg::OP_SHIFT);
            if ((uw.op == uapq_pkg::OP_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (uw.op)
                uapq_pkg::OP_INSERT: begin
                    if (r_count != CNT_W'(uapq_pkg::DEPTH)) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                uapq_pkg::OP_SHIFT_LAST: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload side of the datapath
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[IDX_W-1:0];
        case (uw.op)
            uapq_pkg::OP_LATCH: begin
                if (accept) begin
                    r_act      <= s_axis_tuser;
                    r_in.data  <= s_axis_tdata[31:0];
                    r_in.pri   <= s_axis_tdata[47:32];
                    r_res_data <= '0;
                    r_res_pri  <= '0;
                    r_status   <= uapq_pkg::ST_DONE;
                end
            end
            uapq_pkg::OP_INSERT: begin
                if (r_count == CNT_W'(uapq_pkg::DEPTH)) begin
                    r_status <= uapq_pkg::ST_FULL;
                end
            end
            uapq_pkg::OP_DEL_INIT: begin
                if (r_count == '0) begin
                    r_status <= uapq_pkg::ST_EMPTY;
                end
                r_idx      <= '0;
                r_best_pri <= {1'b1, {PRI_W{1'b0}}};
                r_best_idx <= '0;
            end
            uapq_pkg::OP_SCAN, uapq_pkg::OP_CMP_LAST: begin
                if (uw.op == uapq_pkg::OP_SCAN) begin
                    r_idx <= r_idx + 1'b1;
                end
                // strict compare keeps the earliest entry on a tie
                if (better) begin
                    r_best_pri  <= {1'b0, rd_data.pri};
                    r_best_idx  <= r_rd_idx;
                    r_best_data <= rd_data.data;
                end
            end
            uapq_pkg::OP_SHIFT_PREP: begin
                r_idx      <= CNT_W'(r_best_idx) + 1'b1;
                r_res_data <= r_best_data;
                r_res_pri  <= r_best_pri[PRI_W-1:0];
            end
            uapq_pkg::OP_SHIFT: begin
                r_idx <= r_idx + 1'b1;
            end
            uapq_pkg::OP_FINISH: begin
                if (out_free) begin
                    r_m_tdata <= {3'b000, uapq_pkg::OCC_W'(r_count), r_res_pri, r_res_data};
                    r_m_tuser <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(uapq_pkg::DEPTH))
        else $error("entry count above depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (CNT_W'(wr_addr) < r_count) || (uw.op == uapq_pkg::OP_INSERT))
        else $error("gap-closing write outside held entries");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != uapq_pkg::ST_DONE))
        |-> (m_axis_tdata[47:0] == '0))
        else $error("refused item carries payload");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == uapq_pkg::OP_SHIFT_PREP) |-> (r_best_pri[PRI_W] == 1'b0))
        else $error("delete found no minimum");

endmodule

// File: hdl/uapq_store.sv
module uapq_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [uapq_pkg::IDX_W-1:0] i_wr_addr,
    input  uapq_pkg::t_entry          i_wr_data,
    input  logic [uapq_pkg::IDX_W-1:0] i_rd_addr,
    output uapq_pkg::t_entry          o_rd_data
);

    uapq_pkg::t_entry r_mem [uapq_pkg::DEPTH];
    uapq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
